// ===== rtl/sfp_pkg.sv =====
// ============================================================================
// sfp_pkg - shared types and tables for the settings frame parser
// Character tables for the test sequence and the frame layout, result kinds
// and the status structs passed between the matcher, parser and top level.
// ============================================================================
package sfp_pkg;

   typedef logic [7:0] byte_type;
   typedef byte_type [7:0] settings_type;   // entry 0 = temp_high ... 7 = water_minutes

   localparam int unsigned TEST_LEN = 10;
   localparam int unsigned TPOS_W   = 4;
   localparam int unsigned FPOS_W   = 4;
   localparam int unsigned SLOT_W   = 3;

   localparam logic [TPOS_W-1:0] TEST_LAST  = TPOS_W'(TEST_LEN - 1);
   localparam logic [FPOS_W-1:0] FRAME_LAST = '1;

   localparam byte_type CHAR_ZERO = 8'd48;
   localparam byte_type NO_MARKER = 8'd0;

   localparam logic KIND_FRAME = 1'b0;
   localparam logic KIND_TEST  = 1'b1;

   typedef struct packed {
      logic hit;    // byte advanced the matcher
      logic done;   // last test character seen
   } match_status_type;

   typedef struct packed {
      logic done;   // closing '>' of a frame seen
   } frame_status_type;

   // ||prueba||
   function automatic byte_type test_char(input logic [TPOS_W-1:0] pos);
      byte_type c;
      case (pos)
         4'd0, 4'd1, 4'd8, 4'd9: c = "|";
         4'd2:    c = "p";
         4'd3:    c = "r";
         4'd4:    c = "u";
         4'd5:    c = "e";
         4'd6:    c = "b";
         4'd7:    c = "a";
         default: c = NO_MARKER;
      endcase
      return c;
   endfunction

   // Expected marker per frame position; NO_MARKER on digit-pair positions.
   function automatic byte_type frame_marker(input logic [FPOS_W-1:0] pos);
      byte_type c;
      case (pos)
         4'd0, 4'd1:   c = "<";
         4'd2:         c = "T";
         4'd5:         c = "H";
         4'd8:         c = "I";
         4'd10:        c = "R";
         4'd14, 4'd15: c = ">";
         default:      c = NO_MARKER;
      endcase
      return c;
   endfunction

   function automatic logic [SLOT_W-1:0] frame_slot(input logic [FPOS_W-1:0] pos);
      logic [SLOT_W-1:0] s;
      case (pos)
         4'd4:    s = 3'd1;
         4'd6:    s = 3'd2;
         4'd7:    s = 3'd3;
         4'd9:    s = 3'd4;
         4'd11:   s = 3'd5;
         4'd12:   s = 3'd6;
         4'd13:   s = 3'd7;
         default: s = 3'd0;
      endcase
      return s;
   endfunction

endpackage

// ===== rtl/settings_frame_parser.sv =====
// ============================================================================
// settings_frame_parser - serial settings frame and test sequence recognizer
// Input byte register, matcher and frame parser, result register.
// ============================================================================
// One received character per request on req_. The byte is registered, then
// the test matcher and the frame parser update from the byte register and,
// when a test sequence (||prueba||) or a settings frame (<<T..H..I..R...>>)
// closes, one result is loaded into the output register. Throughput is one
// character per cycle while rsp_tready is high. The single output register
// sets the rate: when a result is held unaccepted, the byte stage stalls and
// req_tready drops.
module settings_frame_parser (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [7:0] temp_high, [15:8] temp_low,
                                    // [23:16] moisture_high, [31:24] moisture_low,
                                    // [39:32] light_hours, [47:40] water_start_hour,
                                    // [55:48] water_start_minute, [63:56] water_minutes
   output logic        rsp_tuser    // [0] result_kind
);

   // byte stage
   logic                 in_valid_ff;
   sfp_pkg::byte_type    in_byte_ff;
   logic                 advance;

   // result stage
   logic                  rsp_valid_ff;
   logic                  rsp_kind_ff, rsp_kind_in;
   sfp_pkg::settings_type rsp_data_ff, rsp_data_in;
   logic                  produce;

   sfp_pkg::match_status_type mstat;
   sfp_pkg::frame_status_type fstat;
   sfp_pkg::settings_type     settings;

   // byte stage moves on when the result register is free or being drained
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
      end
   end

   sfp_matcher u_matcher (
      .clock   (clock),
      .reset   (reset),
      .enable  (advance),
      .rx_byte (in_byte_ff),
      .status  (mstat)
   );

   // bytes consumed by the matcher never reach the frame parser
   sfp_frame u_frame (
      .clock    (clock),
      .reset    (reset),
      .enable   (advance && !mstat.hit),
      .rx_byte  (in_byte_ff),
      .status   (fstat),
      .settings (settings)
   );

   assign produce = mstat.done || fstat.done;

   always_comb begin
      if (mstat.done) begin
         rsp_kind_in = sfp_pkg::KIND_TEST;
         rsp_data_in = '0;
      end else begin
         rsp_kind_in = sfp_pkg::KIND_FRAME;
         rsp_data_in = settings;   // frame close does not touch the store
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= produce;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && produce) begin
         rsp_kind_ff <= rsp_kind_in;
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   a_one_source: assert property (@(posedge clock) disable iff (reset)
      !(mstat.done && fstat.done))
      else $error("matcher and frame parser finished on the same byte");

   a_frame_gated: assert property (@(posedge clock) disable iff (reset)
      fstat.done |-> (advance && !mstat.hit))
      else $error("frame finished on a byte owned by the matcher");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !advance)
      else $error("byte stage advanced over a held result");

   a_test_zero: assert property (@(posedge clock) disable iff (reset)
      (advance && mstat.done) |=> (rsp_tvalid && rsp_tuser == sfp_pkg::KIND_TEST
                                   && rsp_tdata == '0))
      else $error("test result not loaded with zero settings");

endmodule

// ===== rtl/sfp_matcher.sv =====
// ============================================================================
// sfp_matcher - test sequence matcher
// Tracks progress through ||prueba||; any byte that does not advance it
// restarts it at the first character.
// ============================================================================
module sfp_matcher (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      enable,
   input  sfp_pkg::byte_type         rx_byte,
   output sfp_pkg::match_status_type status
);

   logic [sfp_pkg::TPOS_W-1:0] pos_ff, pos_in;
   logic                       in_range;

   assign in_range    = (32'(pos_ff) < sfp_pkg::TEST_LEN);
   assign status.hit  = in_range && (rx_byte == sfp_pkg::test_char(pos_ff));
   assign status.done = status.hit && (pos_ff == sfp_pkg::TEST_LAST);

   always_comb begin
      pos_in = pos_ff;
      if (enable) begin
         if (!status.hit || status.done) begin
            pos_in = '0;
         end else begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule

// ===== rtl/sfp_frame.sv =====
// ============================================================================
// sfp_frame - settings frame parser
// Walks << T dd dd H dd dd I dd R dd dd dd >> and stores each digit pair
// as (c1-48)*10+(c2-48) mod 256. Wrong marker returns to idle.
// ============================================================================
module sfp_frame (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      enable,
   input  sfp_pkg::byte_type         rx_byte,
   output sfp_pkg::frame_status_type status,
   output sfp_pkg::settings_type     settings
);

   logic [sfp_pkg::FPOS_W-1:0] pos_ff, pos_in;
   logic                       phase_ff, phase_in;
   sfp_pkg::settings_type      store_ff, store_in;

   sfp_pkg::byte_type          marker;
   logic [sfp_pkg::SLOT_W-1:0] slot;
   sfp_pkg::byte_type          diff;
   sfp_pkg::byte_type          tens;

   assign marker   = sfp_pkg::frame_marker(pos_ff);
   assign slot     = sfp_pkg::frame_slot(pos_ff);
   assign diff     = rx_byte - sfp_pkg::CHAR_ZERO;
   assign tens     = (diff << 3) + (diff << 1);   // x10, wraps
   assign settings = store_ff;

   always_comb begin
      pos_in      = pos_ff;
      phase_in    = phase_ff;
      store_in    = store_ff;
      status.done = 1'b0;
      if (enable) begin
         if (marker != sfp_pkg::NO_MARKER) begin
            if (rx_byte != marker) begin
               pos_in = '0;
            end else if (pos_ff == sfp_pkg::FRAME_LAST) begin
               pos_in      = '0;
               status.done = 1'b1;
            end else begin
               pos_in = pos_ff + 1'b1;
            end
         end else if (!phase_ff) begin
            store_in[slot] = tens;
            phase_in       = 1'b1;
         end else begin
            store_in[slot] = store_ff[slot] + diff;
            phase_in       = 1'b0;
            pos_in         = pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         phase_ff <= 1'b0;
         store_ff <= '0;
      end else begin
         pos_ff   <= pos_in;
         phase_ff <= phase_in;
         store_ff <= store_in;
      end
   end

endmodule
